FILE: sv/clls_pkg.sv
package clls_pkg;

  localparam int unsigned GRID_SIDE_DEF = 16;
  localparam int unsigned PIXELS        = 256;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned COUNT_W       = 9;
  localparam int unsigned PIN_COUNT     = 17;
  localparam int unsigned PIN_IDX_W     = 5;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FLIP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic write_px;
    logic flip_start;
    logic sweep_step;
    logic div_step;
    logic tick_read;
    logic out_load;
  } clls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_last;
    logic div_last;
    logic out_free;
  } clls_stat_t;

endpackage

FILE: sv/clls_in_if.sv
interface clls_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] pixel_index;
  logic       pixel_value;

  modport source (output valid, output opcode, output pixel_index, output pixel_value,
                  input ready);
  modport sink   (input valid, input opcode, input pixel_index, input pixel_value,
                  output ready);
endinterface

FILE: sv/clls_out_if.sv
interface clls_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] drive_high;
  logic [16:0] output_enable;

  modport source (output valid, output drive_high, output output_enable, input ready);
  modport sink   (input valid, input drive_high, input output_enable, output ready);
endinterface

FILE: sv/clls_ram.sv
module clls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/clls_ctrl.sv
module clls_ctrl
  import clls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  output logic       in_ready_o,
  input  clls_stat_t stat_i,
  output clls_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_TICK  = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_DIV   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        // zero both bitmaps, one entry a cycle
        cmd_o.clear_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(opcode_i))
            OP_WRITE: cmd_o.write_px = 1'b1;
            OP_FLIP: begin
              cmd_o.flip_start = 1'b1;
              state_d          = ST_SWEEP;
            end
            OP_TICK: begin
              cmd_o.tick_read = 1'b1;
              state_d         = ST_TICK;
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // re-derive the next scan slot against the new lit count
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/clls_dp.sv
module clls_dp
  import clls_pkg::*;
#(
  parameter int unsigned GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clls_cmd_t            cmd_i,
  output clls_stat_t           stat_o,
  input  logic [PIX_W-1:0]     pixel_index_i,
  input  logic                 pixel_value_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [PIN_COUNT-1:0] drive_high_o,
  output logic [PIN_COUNT-1:0] output_enable_o
);

  logic                 front_sel_q;
  logic [COUNT_W-1:0]   lit_count_q;
  logic [PIX_W-1:0]     scan_pos_q;
  logic [PIX_W-1:0]     next_pos_q;
  logic [PIX_W-1:0]     sweep_idx_q;
  logic [2:0]           div_cnt_q;
  logic [PIX_W-1:0]     dvd_q;
  logic [PIX_W-1:0]     rem_q;
  logic                 tick_zero_q;
  logic                 out_valid_q;
  logic [PIN_COUNT-1:0] drive_q, enable_q;

  logic                 map_we_a, map_we_b, map_wdata, map_re;
  logic [PIX_W-1:0]     map_waddr, map_raddr;
  logic                 map_a_rdata, map_b_rdata;
  logic                 front_bit, in_grid, list_hit;
  logic [COUNT_W-1:0]   trial;
  logic [PIX_W-1:0]     rem_d;
  logic [COUNT_W-1:0]   pos_inc;
  logic [PIX_W-1:0]     next_after;
  logic [PIX_W-1:0]     list_rdata;
  logic [3:0]           row, col;
  logic [PIN_IDX_W-1:0] hi_pin;
  logic [PIN_COUNT-1:0] drive_d, enable_d;

  // bitmaps: writes go to the back map, the clearing pass zeroes both
  assign map_wdata = cmd_i.clear_step ? 1'b0 : pixel_value_i;
  assign map_waddr = cmd_i.clear_step ? sweep_idx_q : pixel_index_i;
  assign map_we_a  = cmd_i.clear_step || (cmd_i.write_px && !front_sel_q);
  assign map_we_b  = cmd_i.clear_step || (cmd_i.write_px && front_sel_q);

  // read one pixel ahead so the sweep sees each bit in its own cycle
  assign map_re    = cmd_i.flip_start || cmd_i.sweep_step;
  assign map_raddr = cmd_i.flip_start ? '0 : sweep_idx_q + PIX_W'(1);

  clls_ram #(
    .WIDTH (1),
    .DEPTH (PIXELS)
  ) u_map_a (
    .clk_i   (clk_i),
    .we_i    (map_we_a),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_a_rdata)
  );

  clls_ram #(
    .WIDTH (1),
    .DEPTH (PIXELS)
  ) u_map_b (
    .clk_i   (clk_i),
    .we_i    (map_we_b),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_b_rdata)
  );

  // sweep: pick lit pixels of the front map in ascending index order
  assign front_bit = front_sel_q ? map_a_rdata : map_b_rdata;
  assign in_grid   = ({1'b0, sweep_idx_q[7:4]} < PIN_IDX_W'(GRID_SIDE))
                  && ({1'b0, sweep_idx_q[3:0]} < PIN_IDX_W'(GRID_SIDE));
  assign list_hit  = cmd_i.sweep_step && front_bit && in_grid;

  // restoring remainder step, one dividend bit per cycle
  assign trial = {rem_q, dvd_q[PIX_W-1]};
  assign rem_d = (trial >= lit_count_q) ? PIX_W'(trial - lit_count_q) : PIX_W'(trial);

  // slot after the current one; position is always below the lit count here
  assign pos_inc    = {1'b0, next_pos_q} + COUNT_W'(1);
  assign next_after = (pos_inc == lit_count_q) ? '0 : pos_inc[PIX_W-1:0];

  clls_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIXELS)
  ) u_list (
    .clk_i   (clk_i),
    .we_i    (list_hit),
    .waddr_i (lit_count_q[PIX_W-1:0]),
    .wdata_i (sweep_idx_q),
    .re_i    (cmd_i.tick_read),
    .raddr_i (next_pos_q),
    .rdata_o (list_rdata)
  );

  assign row    = list_rdata[7:4];
  assign col    = list_rdata[3:0];
  assign hi_pin = (row == col) ? PIN_IDX_W'(GRID_SIDE) : {1'b0, row};

  always_comb begin
    if (tick_zero_q) begin
      drive_d  = '0;
      enable_d = '0;
    end else begin
      drive_d  = PIN_COUNT'(1) << hi_pin;
      enable_d = (PIN_COUNT'(1) << hi_pin) | (PIN_COUNT'(1) << col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_sel_q <= 1'b0;
      lit_count_q <= '0;
      scan_pos_q  <= '0;
      next_pos_q  <= '0;
      sweep_idx_q <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.flip_start) begin
        front_sel_q <= ~front_sel_q;
        lit_count_q <= '0;
        sweep_idx_q <= '0;
        div_cnt_q   <= '0;
      end
      if (cmd_i.sweep_step || cmd_i.clear_step) begin
        sweep_idx_q <= sweep_idx_q + PIX_W'(1);
      end
      if (list_hit) begin
        lit_count_q <= lit_count_q + COUNT_W'(1);
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 3'd1;
        if (stat_o.div_last) begin
          next_pos_q <= rem_d;
        end
      end
      if (cmd_i.tick_read && (lit_count_q != '0)) begin
        scan_pos_q <= next_pos_q;
        next_pos_q <= next_after;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.flip_start) begin
      rem_q <= '0;
      dvd_q <= scan_pos_q + PIX_W'(1);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[PIX_W-2:0], 1'b0};
    end
    if (cmd_i.tick_read) begin
      tick_zero_q <= (lit_count_q == '0);
    end
    if (cmd_i.out_load) begin
      drive_q  <= drive_d;
      enable_q <= enable_d;
    end
  end

  assign stat_o.sweep_last = (sweep_idx_q == PIX_W'(PIXELS - 1));
  assign stat_o.div_last   = (div_cnt_q == 3'd7);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign drive_high_o    = drive_q;
  assign output_enable_o = enable_q;

endmodule

FILE: sv/charlieplex_led_list_scanner.sv
// Double-buffered 16x16 charlieplexed LED scanner with a compacted list of lit
// pixels. After reset, input is held off while both bitmap memories are
// cleared one entry a cycle. A pixel write lands in the back bitmap. A scan
// tick first reads the lit-pixel list memory (registered read) and then loads
// the output register; a tick that finds the previous beat still waiting at
// the output stays in its load state, with input held off, until the sink
// takes it. It returns drive-high and output-enable masks over 17 pins, pin
// GRID_SIDE serving diagonal pixels, and zero masks when nothing is lit. A
// flip holds off input while it sweeps the new front bitmap one pixel a cycle
// into the list memory (each bitmap read issued in the cycle before its bit
// is used), and then runs a bit-serial remainder that folds the scan position
// into the new lit count. Opcode 3 is accepted and does nothing. A result that
// waits at the output does not block writes or flips.
module charlieplex_led_list_scanner
  import clls_pkg::*;
#(
  parameter int unsigned GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clls_in_if.sink    in_i,
  clls_out_if.source out_o
);

  clls_cmd_t  cmd;
  clls_stat_t stat;

  clls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .opcode_i   (in_i.opcode),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  clls_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .pixel_index_i   (in_i.pixel_index),
    .pixel_value_i   (in_i.pixel_value),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .drive_high_o    (out_o.drive_high),
    .output_enable_o (out_o.output_enable)
  );

  // never overwrite a beat the sink has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("output beat overwritten");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear_step, cmd.write_px, cmd.flip_start, cmd.sweep_step,
              cmd.div_step, cmd.tick_read, cmd.out_load}))
    else $error("overlapping datapath commands");

  a_flip_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flip_start |=> (cmd.sweep_step && !in_i.ready))
    else $error("flip did not start the sweep");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tick_read |=> !in_i.ready)
    else $error("input taken during tick lookup");

endmodule
